/* rtl/core/arxbc_pkg.sv */
// shared types, constants and helper functions for the 128-bit arx block cipher
// no dependencies; imported by the cipher core and its checker
package arxbc_pkg;

    localparam int NUM_ROUNDS = 64;
    localparam int NUM_STAGES = 2 * NUM_ROUNDS;
    localparam int LATENCY    = NUM_STAGES + 1;
    localparam int CFG_IDX_W  = 1;

    typedef logic [63:0] t_word;
    typedef logic [5:0]  t_rot;

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } t_op;

    localparam t_word RND_CONST = 64'h9E37_79B9_7F4A_7C15;
    localparam t_word DEC_SUM   = 64'h2C15_E819_51E9_8155;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

    // round key offset of round rnd: (rnd + 1) * RND_CONST, modulo 2^64
    function automatic t_word key_step(input int unsigned rnd);
        t_word n;
        n = t_word'(rnd + 1);
        return n * RND_CONST;
    endfunction

    function automatic t_word rot_left(input t_word v, input t_rot s);
        logic [127:0] t;
        t = {v, v} << s;
        return t[127:64];
    endfunction

    function automatic t_word rot_right(input t_word v, input t_rot s);
        logic [127:0] t;
        t = {v, v} >> s;
        return t[63:0];
    endfunction

endpackage

/* rtl/core/arx_block_cipher_128.sv */
// pipeline from the start edge to the result strobe: one capture stage plus two
// stages per round over 64 rounds; throughput: one transaction per cycle
// busy never rises: every stage advances each cycle and the receiver cannot stall
// reset (synchronous, active low) clears the key registers and all stage valid bits
// a key write is registered in the key registers, then in the round key registers
// stage depth: one 64-bit add or subtract, one 64-bit barrel rotate and one 64-bit xor
module arx_block_cipher_128
    import arxbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  t_word                i_block_word0,
    input  t_word                i_block_word1,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_word                i_cfg_wdata,
    output logic                 o_strobe,
    output t_word                o_result_word0,
    output t_word                o_result_word1
);

    // key registers
    t_word r_key_low;
    t_word r_key_high;

    // per-round keys for both directions, refreshed every cycle from the key registers
    t_word r_rk0_enc [NUM_ROUNDS];
    t_word r_rk0_dec [NUM_ROUNDS];
    t_word r_rk1_enc [NUM_ROUNDS];
    t_word r_rk1_dec [NUM_ROUNDS];

    // selected round keys per round
    t_word w_k0 [NUM_ROUNDS];
    t_word w_k1 [NUM_ROUNDS];

    // pipeline: stage 0 captures the transaction, stages 1..NUM_STAGES do the rounds
    logic  r_vld [0:NUM_STAGES];
    t_op   r_op  [0:NUM_STAGES-1];
    t_word r_p   [0:NUM_STAGES];
    t_word r_q   [0:NUM_STAGES];
    t_word n_p   [1:NUM_STAGES];
    t_word n_q   [1:NUM_STAGES];

    // every stage moves on each cycle, so a new transaction is always welcome
    assign busy = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    genvar gr;
    genvar gs;

    // round key tables: each entry is one key register plus or minus a constant
    // decryption starts from key_high - S and key_low + S
    for (gr = 0; gr < NUM_ROUNDS; gr++) begin : g_rk
        always_ff @(posedge i_clk) begin
            r_rk0_enc[gr] <= r_key_low  + key_step(gr);
            r_rk1_enc[gr] <= r_key_high - key_step(gr);
            r_rk0_dec[gr] <= r_key_high + (key_step(gr) - DEC_SUM);
            r_rk1_dec[gr] <= r_key_low  + (DEC_SUM - key_step(gr));
        end
    end

    // valid chain, the only pipeline state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NUM_STAGES; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start & ~busy;
            for (int i = 1; i <= NUM_STAGES; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // capture stage
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op[0] <= t_op'(i_opcode);
            r_p[0]  <= i_block_word0;
            r_q[0]  <= i_block_word1;
        end
    end

    // each round splits into two stages:
    //   first half:  p = rotl((p ^ k0) + q, q)
    //   second half: q = (rotr(q, p) - p) ^ k1
    for (gr = 0; gr < NUM_ROUNDS; gr++) begin : g_round
        always_comb begin
            w_k0[gr] = (r_op[2*gr] == OP_DEC) ? r_rk0_dec[gr] : r_rk0_enc[gr];
            w_k1[gr] = (r_op[2*gr+1] == OP_DEC) ? r_rk1_dec[gr] : r_rk1_enc[gr];

            n_p[2*gr+1] = rot_left((r_p[2*gr] ^ w_k0[gr]) + r_q[2*gr], r_q[2*gr][5:0]);
            n_q[2*gr+1] = r_q[2*gr];

            n_p[2*gr+2] = r_p[2*gr+1];
            n_q[2*gr+2] = (rot_right(r_q[2*gr+1], r_p[2*gr+1][5:0]) - r_p[2*gr+1])
                          ^ w_k1[gr];
        end
    end

    // stage registers; the opcode is dropped once the last round key is chosen
    for (gs = 1; gs <= NUM_STAGES; gs++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_p[gs] <= n_p[gs];
            r_q[gs] <= n_q[gs];
        end
        if (gs < NUM_STAGES) begin : g_op
            always_ff @(posedge i_clk) begin
                r_op[gs] <= r_op[gs-1];
            end
        end
    end

    // final word swap is pure wiring
    assign o_strobe       = r_vld[NUM_STAGES];
    assign o_result_word0 = r_q[NUM_STAGES];
    assign o_result_word1 = r_p[NUM_STAGES];

endmodule

/* rtl/core/arxbc_checker.sv */
// port-level checker for the 128-bit arx block cipher, with its bind statement
// depends on arxbc_pkg for the pipeline latency
module arxbc_checker
    import arxbc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    // a reset cycle leaves no result in flight
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

    // every accepted transaction gives a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("missing result after accepted transaction");

    // no result without a transaction accepted at the fixed latency before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result without matching transaction");

    // the pipeline never refuses a transaction
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("busy raised");

endmodule

bind arx_block_cipher_128 arxbc_checker u_arxbc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);
